/* rtl/smallest_enclosing_rect_hit_test_unit_macros.svh */
// Assertion macros for the smallest enclosing rectangle hit test unit.
// Used by the port checker; expects clk and arst_n in scope.
`ifndef SMALLEST_ENCLOSING_RECT_HIT_TEST_UNIT_MACROS_SVH
`define SMALLEST_ENCLOSING_RECT_HIT_TEST_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define SECR_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("secr check failed");

// next-cycle implication, held off during reset
`define SECR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("secr check failed");

`endif

/* rtl/secr_pkg.sv */
// Shared types and constants of the smallest enclosing rectangle hit test unit.
// No dependencies.
package secr_pkg;

	localparam int COORD_W       = 16;
	localparam int ID_W          = 16;
	localparam int SPAN_W        = 16;
	localparam int AREA_W        = 32;
	localparam int STATUS_W      = 3;
	localparam int S_TDATA_W     = 112;
	localparam int M_TDATA_W     = 16;
	localparam int MAX_RECTS_DEF = 64;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_REPLACED = 3'd1,
		ST_FULL     = 3'd2,
		ST_HIT      = 3'd3,
		ST_MISS     = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SPAN,
		S_MUL,
		S_LAUNCH,
		S_SCAN,
		S_RESP
	} fsm_t;

	// item held by the controller, broadcast to every cell
	typedef struct packed {
		logic                      cmd;
		logic [ID_W-1:0]           rect_id;
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		logic [AREA_W-1:0]         area;
	} item_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic [AREA_W-1:0]         area;
		logic [ID_W-1:0]           ident;
	} entry_t;

	// scan token walking the chain, one cell per cycle
	typedef struct packed {
		logic            active;
		logic            done;
		status_t         status;
		logic [ID_W-1:0] hit_id;
	} probe_t;

endpackage

/* rtl/secr_cell.sv */
// One table entry of the hit test chain plus its stage of the scan token.
// Depends on secr_pkg.
module secr_cell #(
	parameter int IDX_W = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IDX_W-1:0]     cell_idx,
	input  logic                 occupied,
	input  secr_pkg::item_t      item,
	input  secr_pkg::probe_t     probe_in,
	input  logic [IDX_W-1:0]     pos_in,
	output secr_pkg::probe_t     probe_out,
	output logic [IDX_W-1:0]     pos_out,
	input  logic                 shift_en,
	input  logic [IDX_W-1:0]     shift_pos,
	input  secr_pkg::entry_t     left_entry,
	output secr_pkg::entry_t     entry
);

	secr_pkg::entry_t entry_q;
	secr_pkg::entry_t new_entry;
	secr_pkg::probe_t probe_q;
	secr_pkg::probe_t probe_d;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] pos_d;
	logic             id_wr;
	logic             in_x;
	logic             in_y;

	assign new_entry = '{ax: item.ax, ay: item.ay, bx: item.bx, by: item.by,
		area: item.area, ident: item.rect_id};

	// inclusive, corners in either order
	assign in_x = (item.px >= entry_q.ax && item.px <= entry_q.bx) ||
		(item.px >= entry_q.bx && item.px <= entry_q.ax);
	assign in_y = (item.py >= entry_q.ay && item.py <= entry_q.by) ||
		(item.py >= entry_q.by && item.py <= entry_q.ay);

	always_comb begin
		probe_d = probe_in;
		pos_d   = pos_in;
		id_wr   = 1'b0;
		if (probe_in.active && !probe_in.done) begin
			if (item.cmd == secr_pkg::CMD_QUERY) begin
				if (occupied && in_x && in_y) begin
					probe_d.done   = 1'b1;
					probe_d.status = secr_pkg::ST_HIT;
					probe_d.hit_id = entry_q.ident;
				end
			end else begin
				priority if (!occupied || entry_q.area > item.area) begin
					probe_d.done   = 1'b1;
					probe_d.status = secr_pkg::ST_INSERTED;
					pos_d          = cell_idx;
				end else if (entry_q.area == item.area) begin
					probe_d.done   = 1'b1;
					probe_d.status = secr_pkg::ST_REPLACED;
					id_wr          = 1'b1;
				end else begin
					// smaller stored area: token moves on untouched
					id_wr = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
		end
	end

	always_ff @(posedge clk) begin
		pos_q <= pos_d;
	end

	// insert commit: cells above the slot take their left neighbor
	always_ff @(posedge clk) begin
		if (shift_en && cell_idx > shift_pos) begin
			entry_q <= left_entry;
		end else if (shift_en && cell_idx == shift_pos) begin
			entry_q <= new_entry;
		end else if (id_wr) begin
			entry_q.ident <= item.rect_id;
		end
	end

	assign probe_out = probe_q;
	assign pos_out   = pos_q;
	assign entry     = entry_q;

endmodule

/* rtl/smallest_enclosing_rect_hit_test_unit.sv */
// Smallest enclosing rectangle hit test unit: keeps up to MAX_RECTS rectangles
// sorted by ascending area and answers point queries with the id of the smallest
// rectangle that contains the point. Depends on secr_pkg and secr_cell.
//
// Usage: one item is taken per s_tvalid/s_tready handshake; s_tuser = 0 inserts
// the rectangle in s_tdata, s_tuser = 1 queries the point in s_tdata. Each item
// gives exactly one result item: m_tuser carries the status (0 inserted, 1 id
// replaced on equal area, 2 table full and dropped, 3 hit, 4 miss) and m_tdata
// the hit id (zero unless hit). The block works on one item at a time: after
// acceptance the area is formed (spans, then one 16x16 multiply), the scan
// token is launched and carried through the chain of MAX_RECTS entry cells one
// cell per cycle, the token's answer is captured and then loaded into the
// output register. s_tready returns high together with the loaded result.
// While the previous result still waits unaccepted in the output register, the
// new result is held back and s_tready stays low until m_tready frees it.
// After reset the table is empty; no clearing pass is needed.
module smallest_enclosing_rect_hit_test_unit #(
	parameter int MAX_RECTS = secr_pkg::MAX_RECTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// rect_id, corner_a_x, corner_a_y, corner_b_x, corner_b_y, point_x, point_y
	input  logic [secr_pkg::S_TDATA_W-1:0]  s_tdata,
	// cmd
	input  logic                            s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// hit_id
	output logic [secr_pkg::M_TDATA_W-1:0]  m_tdata,
	// status
	output logic [secr_pkg::STATUS_W-1:0]   m_tuser
);

	localparam int IDX_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CNT_W = $clog2(MAX_RECTS + 1);
	localparam int CW    = secr_pkg::COORD_W;

	secr_pkg::fsm_t   state_q;
	secr_pkg::fsm_t   state_d;
	secr_pkg::item_t  item_q;
	secr_pkg::entry_t new_entry;

	logic [secr_pkg::SPAN_W-1:0]   span_x_q;
	logic [secr_pkg::SPAN_W-1:0]   span_y_q;
	logic [CNT_W-1:0]              count_q;
	secr_pkg::status_t             res_status_q;
	logic [secr_pkg::ID_W-1:0]     res_id_q;
	logic                          m_tvalid_q;
	logic [secr_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic [secr_pkg::STATUS_W-1:0] m_tuser_q;

	logic        accept;
	logic        launch;
	logic        out_load;
	logic        shift_en;
	logic        table_full;
	logic signed [CW:0] diff_x;
	logic signed [CW:0] diff_y;
	logic [CW:0] abs_x;
	logic [CW:0] abs_y;

	// token chain: index 0 is the launch point, index MAX_RECTS the tail
	secr_pkg::probe_t probe_c [MAX_RECTS+1];
	logic [IDX_W-1:0] pos_c   [MAX_RECTS+1];
	secr_pkg::entry_t entry_c [MAX_RECTS];

	assign accept = s_tvalid && s_tready;

	// control
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		launch   = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			secr_pkg::S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = secr_pkg::S_SPAN;
				end
			end
			secr_pkg::S_SPAN: begin
				state_d = secr_pkg::S_MUL;
			end
			secr_pkg::S_MUL: begin
				state_d = secr_pkg::S_LAUNCH;
			end
			secr_pkg::S_LAUNCH: begin
				launch  = 1'b1;
				state_d = secr_pkg::S_SCAN;
			end
			secr_pkg::S_SCAN: begin
				if (probe_c[MAX_RECTS].active) begin
					state_d = secr_pkg::S_RESP;
				end
			end
			secr_pkg::S_RESP: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = secr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = secr_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= secr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// spans |b - a| fit in 16 bits unsigned
	assign diff_x = {item_q.bx[CW-1], item_q.bx} - {item_q.ax[CW-1], item_q.ax};
	assign diff_y = {item_q.by[CW-1], item_q.by} - {item_q.ay[CW-1], item_q.ay};
	assign abs_x  = diff_x[CW] ? (CW+1)'(-diff_x) : (CW+1)'(diff_x);
	assign abs_y  = diff_y[CW] ? (CW+1)'(-diff_y) : (CW+1)'(diff_y);

	// item payload, area built in place
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q.cmd     <= s_tuser;
			item_q.rect_id <= s_tdata[15:0];
			item_q.ax      <= s_tdata[31:16];
			item_q.ay      <= s_tdata[47:32];
			item_q.bx      <= s_tdata[63:48];
			item_q.by      <= s_tdata[79:64];
			item_q.px      <= s_tdata[95:80];
			item_q.py      <= s_tdata[111:96];
		end
		if (state_q == secr_pkg::S_SPAN) begin
			span_x_q <= abs_x[secr_pkg::SPAN_W-1:0];
			span_y_q <= abs_y[secr_pkg::SPAN_W-1:0];
		end
		if (state_q == secr_pkg::S_MUL) begin
			item_q.area <= secr_pkg::AREA_W'(span_x_q) * secr_pkg::AREA_W'(span_y_q);
		end
	end

	assign new_entry = '{ax: item_q.ax, ay: item_q.ay, bx: item_q.bx, by: item_q.by,
		area: item_q.area, ident: item_q.rect_id};

	// token enters cell 0 with the status it keeps if nothing claims it
	always_comb begin
		probe_c[0].active = launch;
		probe_c[0].done   = 1'b0;
		probe_c[0].status = (item_q.cmd == secr_pkg::CMD_QUERY) ?
			secr_pkg::ST_MISS : secr_pkg::ST_FULL;
		probe_c[0].hit_id = '0;
	end
	assign pos_c[0] = '0;

	// a slot found in front of a larger area is unusable once every cell is taken
	assign table_full = (count_q == CNT_W'(MAX_RECTS));

	// the new entry goes in when the token comes back with a free slot
	assign shift_en = (state_q == secr_pkg::S_SCAN) && probe_c[MAX_RECTS].active &&
		(probe_c[MAX_RECTS].status == secr_pkg::ST_INSERTED) && !table_full;

	for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
		secr_pkg::entry_t left;
		logic             occ;

		if (i == 0) begin : g_head
			assign left = new_entry;
		end else begin : g_body
			assign left = entry_c[i-1];
		end

		assign occ = CNT_W'(i) < count_q;

		secr_cell #(
			.IDX_W(IDX_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (IDX_W'(i)),
			.occupied   (occ),
			.item       (item_q),
			.probe_in   (probe_c[i]),
			.pos_in     (pos_c[i]),
			.probe_out  (probe_c[i+1]),
			.pos_out    (pos_c[i+1]),
			.shift_en   (shift_en),
			.shift_pos  (pos_c[MAX_RECTS]),
			.left_entry (left),
			.entry      (entry_c[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (shift_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// result held until the output register is free
	always_ff @(posedge clk) begin
		if (state_q == secr_pkg::S_SCAN && probe_c[MAX_RECTS].active) begin
			res_status_q <= (probe_c[MAX_RECTS].status == secr_pkg::ST_INSERTED &&
				table_full) ? secr_pkg::ST_FULL : probe_c[MAX_RECTS].status;
			res_id_q     <= probe_c[MAX_RECTS].hit_id;
		end
		if (out_load) begin
			m_tuser_q <= res_status_q;
			m_tdata_q <= res_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

/* rtl/secr_checker.sv */
// Port-level checks for the smallest enclosing rectangle hit test unit, bound
// to the top level. Depends on secr_pkg and the assertion macro header.
`include "smallest_enclosing_rect_hit_test_unit_macros.svh"

module secr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [secr_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic [secr_pkg::STATUS_W-1:0]   m_tuser
);

	// stalled result holds
	`SECR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// id is only reported on a hit
	`SECR_ASSERT_NOW(a_id_zero, m_tvalid && m_tuser != secr_pkg::STATUS_W'(secr_pkg::ST_HIT), m_tdata == '0)
	// one item in flight: busy right after an accept
	`SECR_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	// a new result only shows up at the end of a busy phase
	`SECR_ASSERT_NOW(a_result_after_work, $rose(m_tvalid), !$past(s_tready))

endmodule

bind smallest_enclosing_rect_hit_test_unit secr_checker u_secr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* tb/smallest_enclosing_rect_hit_test_unit_test.sv */
// Self-checking testbench of the smallest enclosing rectangle hit test unit.
// Drives inserts and point queries over the item streams and checks every result.
// Depends on secr_pkg and the unit itself.
module smallest_enclosing_rect_hit_test_unit_test;
	import secr_pkg::*;

	localparam int TABLE_DEPTH = MAX_RECTS_DEF;
	localparam int DRAIN_CYCLES = MAX_RECTS_DEF + 20;
	localparam int HOLDOFF_CYCLES = 600;
	localparam int PHASE_ITEMS = 212;
	localparam logic signed [COORD_W-1:0] CMIN = 16'sh8000;
	localparam logic signed [COORD_W-1:0] CMAX = 16'sh7FFF;
	localparam bit TYPED = 1'b1;
	localparam bit PREDICTED = 1'b0;

	// one stimulus item plus an optional hand-written answer
	typedef struct packed {
		logic                      cmd;
		logic [ID_W-1:0]           id;
		logic signed [COORD_W-1:0] ax;
		logic signed [COORD_W-1:0] ay;
		logic signed [COORD_W-1:0] bx;
		logic signed [COORD_W-1:0] by;
		logic signed [COORD_W-1:0] px;
		logic signed [COORD_W-1:0] py;
		bit                        typed;
		status_t                   st;
		logic [ID_W-1:0]           hid;
	} stim_row_t;

	typedef struct packed {
		status_t         status;
		logic [ID_W-1:0] hit_id;
	} answer_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0]  m_tuser;

	// shadow copy of the rectangle list, kept in ascending area order
	logic signed [COORD_W-1:0] rect_ax [TABLE_DEPTH];
	logic signed [COORD_W-1:0] rect_ay [TABLE_DEPTH];
	logic signed [COORD_W-1:0] rect_bx [TABLE_DEPTH];
	logic signed [COORD_W-1:0] rect_by [TABLE_DEPTH];
	logic [AREA_W-1:0]         rect_area [TABLE_DEPTH];
	logic [ID_W-1:0]           rect_ident [TABLE_DEPTH];
	int                        rect_count = 0;

	answer_t due_answers[$];
	int      n_errors = 0;
	int      n_inserts = 0;
	int      n_queries = 0;
	int      status_seen [5] = '{0, 0, 0, 0, 0};
	int      sender_idle_pct = 0;
	int      rx_stall_pct = 0;
	int      rx_hold_left = 0;
	bit      holdoff_req = 1'b0;

	// directed items; corner and point fields that a command ignores carry junk
	stim_row_t directed_rows [25] = '{
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
			TYPED, ST_MISS, 16'h0000},
		'{CMD_QUERY,  16'hFFFF, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX,
			TYPED, ST_MISS, 16'h0000},
		'{CMD_INSERT, 16'h1234, 16'sd0, 16'sd0, 16'sd10, 16'sd10, CMAX, CMIN,
			TYPED, ST_INSERTED, 16'h0000},
		'{CMD_QUERY,  16'hFFFF, CMIN, CMIN, CMIN, CMIN, 16'sd5, 16'sd5,
			TYPED, ST_HIT, 16'h1234},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd0,
			TYPED, ST_HIT, 16'h1234},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd11, 16'sd5,
			TYPED, ST_MISS, 16'h0000},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1,
			TYPED, ST_MISS, 16'h0000},
		// same area, other corners: only the id changes
		'{CMD_INSERT, 16'hABCD, 16'sd5, 16'sd5, -16'sd5, -16'sd5, 16'sd0, 16'sd0,
			TYPED, ST_REPLACED, 16'h0000},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd3, -16'sd3,
			TYPED, ST_MISS, 16'h0000},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0,
			TYPED, ST_HIT, 16'hABCD},
		// single-point rectangle, area zero
		'{CMD_INSERT, 16'h0001, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd0, 16'sd0,
			TYPED, ST_INSERTED, 16'h0000},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd7, 16'sd7,
			TYPED, ST_HIT, 16'h0001},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd7, 16'sd8,
			PREDICTED, ST_MISS, 16'h0000},
		// full-width segment, also area zero, so it just renames the point
		'{CMD_INSERT, 16'hFFFF, CMIN, 16'sd3, CMAX, 16'sd3, 16'sd0, 16'sd0,
			TYPED, ST_REPLACED, 16'h0000},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd100, 16'sd3,
			TYPED, ST_MISS, 16'h0000},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd7, 16'sd7,
			TYPED, ST_HIT, 16'hFFFF},
		// whole plane, corners given high first
		'{CMD_INSERT, 16'h5A5A, CMAX, CMAX, CMIN, CMIN, 16'sd0, 16'sd0,
			TYPED, ST_INSERTED, 16'h0000},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, CMIN, CMAX,
			TYPED, ST_HIT, 16'h5A5A},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, CMAX, CMIN,
			TYPED, ST_HIT, 16'h5A5A},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd10, 16'sd10,
			TYPED, ST_HIT, 16'hABCD},
		'{CMD_INSERT, 16'h0000, -16'sd20, -16'sd20, -16'sd20, 16'sd20, 16'sd0, 16'sd0,
			TYPED, ST_REPLACED, 16'h0000},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd7, 16'sd7,
			TYPED, ST_HIT, 16'h0000},
		'{CMD_INSERT, 16'hA5A5, 16'sd1, 16'sd2, 16'sd4, 16'sd3, 16'sd0, 16'sd0,
			PREDICTED, ST_INSERTED, 16'h0000},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd2, 16'sd3,
			PREDICTED, ST_MISS, 16'h0000},
		'{CMD_QUERY,  16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd4, 16'sd2,
			PREDICTED, ST_MISS, 16'h0000}
	};

	int idle_by_phase [4] = '{0, 87, 0, 29};
	int stall_by_phase [4] = '{0, 0, 87, 29};

	smallest_enclosing_rect_hit_test_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #5 clk = ~clk;

	function automatic bit covers(int p, int a, int b);
		int lo;
		int hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return (lo <= p) && (p <= hi);
	endfunction

	// applies one item to the shadow list and returns the answer it should give
	function automatic answer_t rect_list_apply(stim_row_t r);
		answer_t   ans;
		int        ax, ay, bx, by, dx, dy, pos, i;
		longint    prod;
		logic [AREA_W-1:0] area;
		ans.status = ST_MISS;
		ans.hit_id = '0;
		if (r.cmd == CMD_INSERT) begin
			ax = int'(r.ax);
			ay = int'(r.ay);
			bx = int'(r.bx);
			by = int'(r.by);
			dx = (ax > bx) ? ax - bx : bx - ax;
			dy = (ay > by) ? ay - by : by - ay;
			prod = longint'(dx) * longint'(dy);
			area = prod[AREA_W-1:0];
			pos = rect_count;
			for (i = 0; i < rect_count; i++) begin
				if (rect_area[i] == area) begin
					// equal area: rename only, even when the list is full
					rect_ident[i] = r.id;
					ans.status = ST_REPLACED;
					return ans;
				end
				if (rect_area[i] > area) begin
					pos = i;
					break;
				end
			end
			if (rect_count >= TABLE_DEPTH) begin
				ans.status = ST_FULL;
				return ans;
			end
			for (i = rect_count; i > pos; i--) begin
				rect_ax[i] = rect_ax[i-1];
				rect_ay[i] = rect_ay[i-1];
				rect_bx[i] = rect_bx[i-1];
				rect_by[i] = rect_by[i-1];
				rect_area[i] = rect_area[i-1];
				rect_ident[i] = rect_ident[i-1];
			end
			rect_ax[pos] = r.ax;
			rect_ay[pos] = r.ay;
			rect_bx[pos] = r.bx;
			rect_by[pos] = r.by;
			rect_area[pos] = area;
			rect_ident[pos] = r.id;
			rect_count++;
			ans.status = ST_INSERTED;
			return ans;
		end
		// first match in ascending area order is the smallest enclosing one
		for (i = 0; i < rect_count; i++) begin
			if (covers(int'(r.px), int'(rect_ax[i]), int'(rect_bx[i])) &&
				covers(int'(r.py), int'(rect_ay[i]), int'(rect_by[i]))) begin
				ans.status = ST_HIT;
				ans.hit_id = rect_ident[i];
				return ans;
			end
		end
		return ans;
	endfunction

	function automatic logic [COORD_W-1:0] extreme_coord();
		case ($urandom_range(0, 3))
			0: return CMIN;
			1: return CMAX;
			2: return '0;
			default: return COORD_W'($urandom);
		endcase
	endfunction

	// mostly small or medium boxes, half of them crowded near the origin so they nest
	function automatic stim_row_t random_insert();
		stim_row_t r;
		int        shape, dx, dy, x0, y0;
		r = '0;
		r.cmd = CMD_INSERT;
		r.id = ID_W'($urandom);
		r.px = COORD_W'($urandom);
		r.py = COORD_W'($urandom);
		r.typed = PREDICTED;
		shape = $urandom_range(0, 99);
		if (shape < 85) begin
			dx = (shape < 60) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
			dy = (shape < 60) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
			if ($urandom_range(0, 1)) begin
				x0 = int'($urandom_range(0, 80)) - 40 - dx / 2;
				y0 = int'($urandom_range(0, 80)) - 40 - dy / 2;
			end else begin
				x0 = int'($urandom_range(0, 65535 - dx)) - 32768;
				y0 = int'($urandom_range(0, 65535 - dy)) - 32768;
			end
			if ($urandom_range(0, 1)) begin
				r.ax = x0[15:0];
				r.bx = 16'(x0 + dx);
			end else begin
				r.bx = x0[15:0];
				r.ax = 16'(x0 + dx);
			end
			if ($urandom_range(0, 1)) begin
				r.ay = y0[15:0];
				r.by = 16'(y0 + dy);
			end else begin
				r.by = y0[15:0];
				r.ay = 16'(y0 + dy);
			end
		end else if (shape < 95) begin
			r.ax = COORD_W'($urandom);
			r.ay = COORD_W'($urandom);
			r.bx = COORD_W'($urandom);
			r.by = COORD_W'($urandom);
		end else begin
			r.ax = extreme_coord();
			r.ay = extreme_coord();
			r.bx = extreme_coord();
			r.by = extreme_coord();
		end
		return r;
	endfunction

	// mostly points aimed at a stored box: inside, on its border, or just past it
	function automatic stim_row_t random_query();
		stim_row_t r;
		int        pick, k, xlo, xhi, ylo, yhi, xv, yv;
		r = '0;
		r.cmd = CMD_QUERY;
		r.id = ID_W'($urandom);
		r.ax = COORD_W'($urandom);
		r.ay = COORD_W'($urandom);
		r.bx = COORD_W'($urandom);
		r.by = COORD_W'($urandom);
		r.px = COORD_W'($urandom);
		r.py = COORD_W'($urandom);
		r.typed = PREDICTED;
		pick = $urandom_range(0, 99);
		if (rect_count > 0 && pick < 80) begin
			k = $urandom_range(0, rect_count - 1);
			xlo = (rect_ax[k] < rect_bx[k]) ? int'(rect_ax[k]) : int'(rect_bx[k]);
			xhi = (rect_ax[k] < rect_bx[k]) ? int'(rect_bx[k]) : int'(rect_ax[k]);
			ylo = (rect_ay[k] < rect_by[k]) ? int'(rect_ay[k]) : int'(rect_by[k]);
			yhi = (rect_ay[k] < rect_by[k]) ? int'(rect_by[k]) : int'(rect_ay[k]);
			xv = xlo + int'($urandom_range(0, xhi - xlo));
			yv = ylo + int'($urandom_range(0, yhi - ylo));
			if (pick < 20) begin
				xv = $urandom_range(0, 1) ? xlo : xhi;
				yv = $urandom_range(0, 1) ? ylo : yhi;
			end else if (pick >= 65) begin
				if (xlo > -32768)
					xv = xlo - 1;
				else if (xhi < 32767)
					xv = xhi + 1;
			end
			r.px = xv[15:0];
			r.py = yv[15:0];
		end
		return r;
	endfunction

	// offers one item, waits for the handshake and records the answer it is owed
	task automatic offer_item(input stim_row_t row);
		answer_t ans;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = row.cmd;
		s_tdata = {row.py, row.px, row.by, row.bx, row.ay, row.ax, row.id};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ans = rect_list_apply(row);
		if (row.typed) begin
			ans.status = row.st;
			ans.hit_id = row.hid;
		end
		due_answers.push_back(ans);
		if (row.cmd == CMD_INSERT)
			n_inserts++;
		else
			n_queries++;
		@(negedge clk);
	endtask

	task automatic wait_all_answered();
		s_tvalid = 1'b0;
		while (due_answers.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// receiver: random stalls, plus a long hold-off on request so the unit backs up
	always @(negedge clk) begin
		if (holdoff_req) begin
			rx_hold_left = HOLDOFF_CYCLES;
			holdoff_req = 1'b0;
		end
		if (rx_hold_left > 0) begin
			m_tready = 1'b0;
			rx_hold_left--;
		end else begin
			m_tready = ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	// result checker against the oldest owed answer
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (m_tuser < 5)
				status_seen[m_tuser]++;
			if (due_answers.size() == 0) begin
				$display("%0t: unexpected result, got status %0d id %h", $time, m_tuser, m_tdata);
				n_errors++;
			end else begin
				want = due_answers.pop_front();
				if (m_tuser !== want.status || m_tdata !== want.hit_id) begin
					$display("%0t: mismatch, expected status %0d id %h, got status %0d id %h",
						$time, want.status, want.hit_id, m_tuser, m_tdata);
					n_errors++;
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		int ph;
		int n;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (n = 0; n < $size(directed_rows); n++)
			offer_item(directed_rows[n]);
		wait_all_answered();

		// pacing phases; inserts are a minority so the list fills partway through
		for (ph = 0; ph < 4; ph++) begin
			sender_idle_pct = idle_by_phase[ph];
			rx_stall_pct = stall_by_phase[ph];
			if (ph == 3)
				holdoff_req = 1'b1;
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if ($urandom_range(0, 99) < 30)
					offer_item(random_insert());
				else
					offer_item(random_query());
			end
			wait_all_answered();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Ran %0d inserts and %0d queries under four pacing phases; list held %0d boxes.",
			n_inserts, n_queries, rect_count);
		$display("Results: %0d new, %0d renamed, %0d dropped full, %0d hits, %0d misses.",
			status_seen[ST_INSERTED], status_seen[ST_REPLACED], status_seen[ST_FULL],
			status_seen[ST_HIT], status_seen[ST_MISS]);
		if (n_errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
